// File: hdl/assert_macros.svh
// Assertion macros included by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/dspbw_pkg.sv
// Types, constants and helpers for the dual screen pixel blend writer
`timescale 1ns / 1ps

package dspbw_pkg;

	localparam int SMALL_ROW_PITCH = 896;
	localparam int SMALL_HALF_PIXELS_DEF = 524288;
	localparam int TV_HALF_PIXELS_DEF = 2097152;
	localparam int SCALE_FRAC_BITS = 3;
	localparam int MAX_SCALE = 24;

	localparam int POS_W = 12;
	localparam int CHAN_W = 8;
	localparam int PIX_W = 3 * CHAN_W;
	localparam int PITCH_W = 12;
	localparam int SCALE_W = 5;
	localparam int SMALL_PIX_W = 20;
	localparam int TV_PIX_W = 22;
	localparam int IDX_OUT_W = 21;
	localparam int LIM_W = 23;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 5;

	// Scaled coordinate width: covers floor(4096 * MAX_SCALE / 2^SCALE_FRAC_BITS)
	localparam int COORD_W = $clog2((((1 << POS_W) * MAX_SCALE) >> SCALE_FRAC_BITS) + 1);
	// Second multiplier operand: TV pitch, the small-screen pitch constant or the TV scale
	localparam int MUL_B_W = 13;
	localparam int PROD_W = COORD_W + MUL_B_W + 1;

	localparam logic [CHAN_W-1:0] ALPHA_FULL = 8'hFF;
	localparam logic [CHAN_W-1:0] ALPHA_NONE = 8'h00;

	// Register indexes (byte address / 4)
	localparam logic [2:0] REG_BACK_BUFFER = 3'd0;
	localparam logic [2:0] REG_SMALL_PIXELS = 3'd1;
	localparam logic [2:0] REG_TV_PIXELS = 3'd2;
	localparam logic [2:0] REG_TV_ROW_PITCH = 3'd3;
	localparam logic [2:0] REG_TV_SCALE = 3'd4;

	localparam logic [SMALL_PIX_W-1:0] SMALL_PIXELS_RST = 20'd430080;
	localparam logic [TV_PIX_W-1:0] TV_PIXELS_RST = 22'd921600;
	localparam logic [PITCH_W-1:0] TV_ROW_PITCH_RST = 12'd1280;
	localparam logic [SCALE_W-1:0] TV_SCALE_RST = 5'd12;

	typedef struct packed {
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] alpha;
	} cmd_t;

	typedef struct packed {
		logic screen;
		logic half;
		logic [IDX_OUT_W-1:0] pixel_index;
		logic [CHAN_W-1:0] out_red;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_blue;
		logic last;
	} result_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL_SMALL,
		ST_MUL_X0,
		ST_MUL_X1,
		ST_MUL_Y0,
		ST_MUL_Y1,
		ST_MUL_ROW,
		ST_SMALL_WR,
		ST_TV_SCAN,
		ST_TV_WR,
		ST_FLUSH
	} state_t;

	// One channel of the blend: (c*a + old*(255-a)) >> 8
	function automatic logic [CHAN_W-1:0] mix(
		input logic [CHAN_W-1:0] c,
		input logic [CHAN_W-1:0] old,
		input logic [CHAN_W-1:0] a
	);
		logic [2*CHAN_W-1:0] p_new;
		logic [2*CHAN_W-1:0] p_old;
		logic [2*CHAN_W-1:0] sum;
		p_new = {{CHAN_W{1'b0}}, c} * {{CHAN_W{1'b0}}, a};
		p_old = {{CHAN_W{1'b0}}, old} * {{CHAN_W{1'b0}}, ALPHA_FULL - a};
		sum = p_new + p_old;
		return sum[2*CHAN_W-1:CHAN_W];
	endfunction

endpackage

// File: hdl/dspbw_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module dspbw_ram #(
	parameter int WIDTH = dspbw_pkg::PIX_W,
	parameter int DEPTH = 2 * dspbw_pkg::SMALL_HALF_PIXELS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/dual_screen_pixel_blend_writer.sv
// Top level of the dual screen pixel blend writer
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Dual screen pixel blend writer. Each draw command (start high while busy is
// low) blends one RGBA pixel into the back half of the small-screen store and
// replicates it over the scaled rectangle of the TV store. Every command write
// to a store is reported once on result, marked by a one-cycle strobe; the
// receiver cannot stall, so it must take each transfer in the cycle it appears,
// and last marks the final transfer of a command. After reset the block clears
// both stores in full, one entry of each per cycle, and holds busy high
// meanwhile; register writes over the APB port are taken at any time but are
// meant to change only while busy is low. A command with alpha zero is dropped
// and leaves busy low. Otherwise one shared multiply-add unit works out the
// small-screen index and the four TV rectangle edges and the first TV row base
// in the states MUL_SMALL, MUL_X0, MUL_X1, MUL_Y0, MUL_Y1 and MUL_ROW, the last
// of which also issues the small-screen read; the small-screen write follows
// when its index is in bounds, each TV pixel of the rectangle gets a scan state
// (which issues its read) followed by a blend-and-write state when it is in
// bounds, each TV row ends with a scan state that steps to the next row, and a
// final scan state and the flush state end the command. busy stays high until
// then, so a new command is taken only once the last one is done; the scale is
// saturated at 3.0, and the last result transfer sits in the first cycle with
// busy low again.
module dual_screen_pixel_blend_writer #(
	parameter int SMALL_HALF_PIXELS = dspbw_pkg::SMALL_HALF_PIXELS_DEF,
	parameter int TV_HALF_PIXELS = dspbw_pkg::TV_HALF_PIXELS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// command channel
	input  logic                             start,
	output logic                             busy,
	input  dspbw_pkg::cmd_t                  cmd,
	// result channel
	output logic                             strobe,
	output dspbw_pkg::result_t               result,
	// APB register port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [dspbw_pkg::ADDR_W-1:0]     paddr,
	input  logic [dspbw_pkg::DATA_W-1:0]     pwdata,
	output logic [dspbw_pkg::DATA_W-1:0]     prdata,
	output logic                             pready
);

	localparam int S_DEPTH = 2 * SMALL_HALF_PIXELS;
	localparam int T_DEPTH = 2 * TV_HALF_PIXELS;
	localparam int S_AW = $clog2(S_DEPTH);
	localparam int T_AW = $clog2(T_DEPTH);
	localparam int CLR_DEPTH = (S_DEPTH > T_DEPTH) ? S_DEPTH : T_DEPTH;
	localparam int CLR_AW = $clog2(CLR_DEPTH);

	localparam int CW = dspbw_pkg::COORD_W;
	localparam int BW = dspbw_pkg::MUL_B_W;
	localparam int PW = dspbw_pkg::PROD_W;
	localparam int LW = dspbw_pkg::LIM_W;
	localparam int CH = dspbw_pkg::CHAN_W;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic                                  back_buffer_q;
	logic [dspbw_pkg::SMALL_PIX_W-1:0]     small_pixels_q;
	logic [dspbw_pkg::TV_PIX_W-1:0]        tv_pixels_q;
	logic [dspbw_pkg::PITCH_W-1:0]         tv_row_pitch_q;
	logic [dspbw_pkg::SCALE_W-1:0]         tv_scale_q;
	logic                                  cfg_wr;
	logic [2:0]                            cfg_idx;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign cfg_idx = paddr[4:2];

	// Write on the access phase; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			back_buffer_q <= 1'b0;
			small_pixels_q <= dspbw_pkg::SMALL_PIXELS_RST;
			tv_pixels_q <= dspbw_pkg::TV_PIXELS_RST;
			tv_row_pitch_q <= dspbw_pkg::TV_ROW_PITCH_RST;
			tv_scale_q <= dspbw_pkg::TV_SCALE_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				dspbw_pkg::REG_BACK_BUFFER: back_buffer_q <= pwdata[0];
				dspbw_pkg::REG_SMALL_PIXELS: begin
					small_pixels_q <= pwdata[dspbw_pkg::SMALL_PIX_W-1:0];
				end
				dspbw_pkg::REG_TV_PIXELS: tv_pixels_q <= pwdata[dspbw_pkg::TV_PIX_W-1:0];
				dspbw_pkg::REG_TV_ROW_PITCH: begin
					tv_row_pitch_q <= pwdata[dspbw_pkg::PITCH_W-1:0];
				end
				dspbw_pkg::REG_TV_SCALE: tv_scale_q <= pwdata[dspbw_pkg::SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (cfg_idx)
			dspbw_pkg::REG_BACK_BUFFER: prdata = dspbw_pkg::DATA_W'(back_buffer_q);
			dspbw_pkg::REG_SMALL_PIXELS: prdata = dspbw_pkg::DATA_W'(small_pixels_q);
			dspbw_pkg::REG_TV_PIXELS: prdata = dspbw_pkg::DATA_W'(tv_pixels_q);
			dspbw_pkg::REG_TV_ROW_PITCH: prdata = dspbw_pkg::DATA_W'(tv_row_pitch_q);
			dspbw_pkg::REG_TV_SCALE: prdata = dspbw_pkg::DATA_W'(tv_scale_q);
			default: prdata = '0;
		endcase
	end

	// Saturate the pixel counts at the half sizes and the scale at its maximum
	logic [LW-1:0]                  small_lim;
	logic [LW-1:0]                  tv_lim;
	logic [dspbw_pkg::SCALE_W-1:0]  scale_sat;

	always_comb begin
		small_lim = (LW'(small_pixels_q) < LW'(SMALL_HALF_PIXELS)) ?
			LW'(small_pixels_q) : LW'(SMALL_HALF_PIXELS);
		tv_lim = (LW'(tv_pixels_q) < LW'(TV_HALF_PIXELS)) ?
			LW'(tv_pixels_q) : LW'(TV_HALF_PIXELS);
		scale_sat = (tv_scale_q > dspbw_pkg::SCALE_W'(dspbw_pkg::MAX_SCALE)) ?
			dspbw_pkg::SCALE_W'(dspbw_pkg::MAX_SCALE) : tv_scale_q;
	end

	// ------------------------------------------------------------------
	// Sequencer and datapath registers
	// ------------------------------------------------------------------
	dspbw_pkg::state_t state_q, state_d;

	logic [CLR_AW-1:0]        clr_q;
	logic                     clr_done;
	dspbw_pkg::cmd_t          cmd_q;
	logic                     half_q;
	logic [PW-1:0]            sidx_q;
	logic [CW-1:0]            x0_q, x1_q, y0_q, y1_q;
	logic [CW-1:0]            xx_q, yy_q;
	logic [PW-1:0]            rowbase_q;
	logic                     pend_v_q;
	dspbw_pkg::result_t       pend_q;
	logic                     strobe_q;
	dspbw_pkg::result_t       res_q;

	// Shared multiply-add unit: a*b + c
	logic [CW-1:0]            mul_a;
	logic [BW-1:0]            mul_b;
	logic [dspbw_pkg::POS_W-1:0] mul_c;
	logic [CW+BW-1:0]         mul_p;
	logic [PW-1:0]            mul_res;
	logic [CW-1:0]            mul_coord;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		mul_c = '0;
		case (state_q)
			dspbw_pkg::ST_MUL_SMALL: begin
				mul_a = CW'(cmd_q.pos_y);
				mul_b = BW'(dspbw_pkg::SMALL_ROW_PITCH);
				mul_c = cmd_q.pos_x;
			end
			dspbw_pkg::ST_MUL_X0: begin
				mul_a = CW'(cmd_q.pos_x);
				mul_b = BW'(scale_sat);
			end
			dspbw_pkg::ST_MUL_X1: begin
				mul_a = CW'(cmd_q.pos_x) + CW'(1);
				mul_b = BW'(scale_sat);
			end
			dspbw_pkg::ST_MUL_Y0: begin
				mul_a = CW'(cmd_q.pos_y);
				mul_b = BW'(scale_sat);
			end
			dspbw_pkg::ST_MUL_Y1: begin
				mul_a = CW'(cmd_q.pos_y) + CW'(1);
				mul_b = BW'(scale_sat);
			end
			dspbw_pkg::ST_MUL_ROW: begin
				mul_a = y0_q;
				mul_b = BW'(tv_row_pitch_q);
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign mul_res = PW'(mul_p) + PW'(mul_c);
	assign mul_coord = CW'(mul_res >> dspbw_pkg::SCALE_FRAC_BITS);

	// Index and bounds of the current pixel in each store
	logic [PW:0]              tv_idx;
	logic                     tv_in;
	logic                     small_in;
	logic [S_AW-1:0]          small_addr;
	logic [T_AW-1:0]          tv_addr;

	assign tv_idx = (PW + 1)'(xx_q) + (PW + 1)'(rowbase_q);
	assign tv_in = tv_idx < (PW + 1)'(tv_lim);
	assign small_in = sidx_q < PW'(small_lim);
	assign small_addr = half_q ? (S_AW'(SMALL_HALF_PIXELS) + sidx_q[S_AW-1:0]) :
		sidx_q[S_AW-1:0];
	assign tv_addr = half_q ? (T_AW'(TV_HALF_PIXELS) + tv_idx[T_AW-1:0]) :
		tv_idx[T_AW-1:0];
	assign clr_done = (clr_q == CLR_AW'(CLR_DEPTH - 1));

	// ------------------------------------------------------------------
	// Frame stores
	// ------------------------------------------------------------------
	logic                     s_we, t_we;
	logic [S_AW-1:0]          s_waddr;
	logic [T_AW-1:0]          t_waddr;
	logic [dspbw_pkg::PIX_W-1:0] s_wdata, t_wdata;
	logic [dspbw_pkg::PIX_W-1:0] s_rdata, t_rdata;
	logic [dspbw_pkg::PIX_W-1:0] old_pix, new_pix;
	dspbw_pkg::result_t       wr_rec;
	dspbw_pkg::result_t       flush_rec;
	logic                     wr_any;

	dspbw_ram #(
		.WIDTH (dspbw_pkg::PIX_W),
		.DEPTH (S_DEPTH)
	) u_small_store (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (small_addr),
		.rdata (s_rdata)
	);

	dspbw_ram #(
		.WIDTH (dspbw_pkg::PIX_W),
		.DEPTH (T_DEPTH)
	) u_tv_store (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.raddr (tv_addr),
		.rdata (t_rdata)
	);

	// Blend against the value read in the previous cycle; full alpha overwrites
	always_comb begin
		old_pix = (state_q == dspbw_pkg::ST_TV_WR) ? t_rdata : s_rdata;
		if (cmd_q.alpha == dspbw_pkg::ALPHA_FULL) begin
			new_pix = {cmd_q.red, cmd_q.green, cmd_q.blue};
		end else begin
			new_pix = {
				dspbw_pkg::mix(cmd_q.red, old_pix[3*CH-1:2*CH], cmd_q.alpha),
				dspbw_pkg::mix(cmd_q.green, old_pix[2*CH-1:CH], cmd_q.alpha),
				dspbw_pkg::mix(cmd_q.blue, old_pix[CH-1:0], cmd_q.alpha)
			};
		end
		wr_rec.screen = (state_q == dspbw_pkg::ST_TV_WR);
		wr_rec.half = half_q;
		wr_rec.pixel_index = (state_q == dspbw_pkg::ST_TV_WR) ?
			tv_idx[dspbw_pkg::IDX_OUT_W-1:0] : sidx_q[dspbw_pkg::IDX_OUT_W-1:0];
		wr_rec.out_red = new_pix[3*CH-1:2*CH];
		wr_rec.out_green = new_pix[2*CH-1:CH];
		wr_rec.out_blue = new_pix[CH-1:0];
		wr_rec.last = 1'b0;
		// the held-back write, marked as the final one of the command
		flush_rec = pend_q;
		flush_rec.last = 1'b1;
	end

	// Next state and store write controls
	always_comb begin
		state_d = state_q;
		busy = 1'b1;
		s_we = 1'b0;
		t_we = 1'b0;
		s_waddr = small_addr;
		t_waddr = tv_addr;
		s_wdata = new_pix;
		t_wdata = new_pix;
		wr_any = 1'b0;
		case (state_q)
			dspbw_pkg::ST_CLEAR: begin
				// sweep both stores with zeros, one entry of each per cycle
				s_we = ({1'b0, clr_q} < (CLR_AW + 1)'(S_DEPTH));
				t_we = ({1'b0, clr_q} < (CLR_AW + 1)'(T_DEPTH));
				s_waddr = clr_q[S_AW-1:0];
				t_waddr = clr_q[T_AW-1:0];
				s_wdata = '0;
				t_wdata = '0;
				if (clr_done) begin
					state_d = dspbw_pkg::ST_IDLE;
				end
			end
			dspbw_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start && (cmd.alpha != dspbw_pkg::ALPHA_NONE)) begin
					state_d = dspbw_pkg::ST_MUL_SMALL;
				end
			end
			dspbw_pkg::ST_MUL_SMALL: state_d = dspbw_pkg::ST_MUL_X0;
			dspbw_pkg::ST_MUL_X0: state_d = dspbw_pkg::ST_MUL_X1;
			dspbw_pkg::ST_MUL_X1: state_d = dspbw_pkg::ST_MUL_Y0;
			dspbw_pkg::ST_MUL_Y0: state_d = dspbw_pkg::ST_MUL_Y1;
			dspbw_pkg::ST_MUL_Y1: state_d = dspbw_pkg::ST_MUL_ROW;
			dspbw_pkg::ST_MUL_ROW: begin
				// the small-store read is issued in this cycle
				state_d = small_in ? dspbw_pkg::ST_SMALL_WR : dspbw_pkg::ST_TV_SCAN;
			end
			dspbw_pkg::ST_SMALL_WR: begin
				s_we = 1'b1;
				wr_any = 1'b1;
				state_d = dspbw_pkg::ST_TV_SCAN;
			end
			dspbw_pkg::ST_TV_SCAN: begin
				if (yy_q >= y1_q) begin
					state_d = dspbw_pkg::ST_FLUSH;
				end else if ((xx_q < x1_q) && tv_in) begin
					state_d = dspbw_pkg::ST_TV_WR;
				end
			end
			dspbw_pkg::ST_TV_WR: begin
				t_we = 1'b1;
				wr_any = 1'b1;
				state_d = dspbw_pkg::ST_TV_SCAN;
			end
			dspbw_pkg::ST_FLUSH: state_d = dspbw_pkg::ST_IDLE;
			default: state_d = dspbw_pkg::ST_IDLE;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dspbw_pkg::ST_CLEAR;
			clr_q <= '0;
			pend_v_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q <= state_d;
			strobe_q <= 1'b0;
			if (state_q == dspbw_pkg::ST_CLEAR) begin
				clr_q <= clr_q + CLR_AW'(1);
			end
			// hold each write back one step so that the final one can carry last
			if (wr_any) begin
				pend_v_q <= 1'b1;
				strobe_q <= pend_v_q;
			end else if (state_q == dspbw_pkg::ST_FLUSH) begin
				pend_v_q <= 1'b0;
				strobe_q <= pend_v_q;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			dspbw_pkg::ST_IDLE: begin
				cmd_q <= cmd;
				half_q <= back_buffer_q;
			end
			dspbw_pkg::ST_MUL_SMALL: sidx_q <= mul_res;
			dspbw_pkg::ST_MUL_X0: x0_q <= mul_coord;
			dspbw_pkg::ST_MUL_X1: x1_q <= mul_coord;
			dspbw_pkg::ST_MUL_Y0: y0_q <= mul_coord;
			dspbw_pkg::ST_MUL_Y1: y1_q <= mul_coord;
			dspbw_pkg::ST_MUL_ROW: begin
				rowbase_q <= mul_res;
				xx_q <= x0_q;
				yy_q <= y0_q;
			end
			dspbw_pkg::ST_TV_SCAN: begin
				if (yy_q < y1_q) begin
					if (xx_q >= x1_q) begin
						// advance to the next TV row
						xx_q <= x0_q;
						yy_q <= yy_q + CW'(1);
						rowbase_q <= rowbase_q + PW'(tv_row_pitch_q);
					end else if (!tv_in) begin
						// drop an out-of-bounds pixel
						xx_q <= xx_q + CW'(1);
					end
				end
			end
			dspbw_pkg::ST_TV_WR: xx_q <= xx_q + CW'(1);
			default: ;
		endcase

		if (wr_any) begin
			pend_q <= wr_rec;
			res_q <= pend_q;
		end else if (state_q == dspbw_pkg::ST_FLUSH) begin
			res_q <= flush_rec;
		end
	end

	assign strobe = strobe_q;
	assign result = res_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`ASSERT_NEXT(a_alpha_zero_idle, clk, arst_n,
		(state_q == dspbw_pkg::ST_IDLE) && start && (cmd.alpha == dspbw_pkg::ALPHA_NONE),
		!busy, "alpha zero command left the block busy")

	`ASSERT_SAME(a_no_result_in_clear, clk, arst_n,
		state_q == dspbw_pkg::ST_CLEAR, !strobe_q, "result transfer during store clear")

	`ASSERT_NEXT(a_last_then_quiet, clk, arst_n,
		strobe_q && res_q.last, !strobe_q, "transfer directly after the last one")

	`ASSERT_SAME(a_idle_nothing_pending, clk, arst_n,
		state_q == dspbw_pkg::ST_IDLE, !pend_v_q, "write still pending while idle")

endmodule
